// ===== sv/pgs_pkg.sv =====
// Shared constants, codes and port bundles of the packed 3-bit grid store.
package pgs_pkg;

   localparam int MAX_ROWS   = 32;
   localparam int MAX_COLS   = 32;
   localparam int CELL_BITS  = 3;
   localparam int BYTE_BITS  = 8;
   localparam int BANK_BYTES = (MAX_ROWS * MAX_COLS * CELL_BITS + 7) / 8;
   // one spare entry so the upper byte of the last pair always has a home
   localparam int HALF_DEPTH = BANK_BYTES / 2 + 1;
   localparam int HALF_AW    = $clog2(HALF_DEPTH);

   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int COL_W = $clog2(MAX_COLS);
   localparam int DIM_W = $clog2((MAX_ROWS > MAX_COLS ? MAX_ROWS : MAX_COLS) + 1);
   localparam int POS_W = $clog2(MAX_ROWS * MAX_COLS);
   localparam int BIT_W = $clog2(MAX_ROWS * MAX_COLS * CELL_BITS + 1);
   localparam int IDX_W = BIT_W - 3;
   localparam int OFF_W = 3;
   localparam int CNT_W = 3;
   localparam int ACC_W = BYTE_BITS - 1;

   localparam logic [CELL_BITS-1:0] CELL_MASK = '1;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_RESIZE = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef struct packed {
      logic             bank;
      logic [IDX_W-1:0] idx;
   } mem_rd_type;

   typedef struct packed {
      logic                 bank;
      logic [IDX_W-1:0]     idx;
      logic                 lo_en;
      logic                 hi_en;
      logic [BYTE_BITS-1:0] lo;
      logic [BYTE_BITS-1:0] hi;
   } mem_wr_type;

endpackage

// ===== sv/pgs_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered data.
module pgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 193
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pgs_banks.sv =====
// Two byte banks, each split into even and odd halves so both bytes of a pair are read or written together.
module pgs_banks (
   input  logic                                clock,
   input  pgs_pkg::mem_rd_type                 rd,
   input  pgs_pkg::mem_wr_type                 wr,
   output logic [2*pgs_pkg::BYTE_BITS-1:0]     rd_pair
);
   import pgs_pkg::*;

   logic [HALF_AW-1:0]   even_waddr;
   logic [HALF_AW-1:0]   odd_waddr;
   logic [BYTE_BITS-1:0] even_wdata;
   logic [BYTE_BITS-1:0] odd_wdata;
   logic                 even_we;
   logic                 odd_we;
   logic [HALF_AW-1:0]   even_raddr;
   logic [HALF_AW-1:0]   odd_raddr;
   logic [BYTE_BITS-1:0] even_q [2];
   logic [BYTE_BITS-1:0] odd_q [2];
   logic                 rd_bank_ff;
   logic                 rd_odd_ff;

   // route the low byte to the half that holds byte idx, the high byte to the other
   always_comb begin
      odd_waddr = HALF_AW'(wr.idx >> 1);
      if (wr.idx[0]) begin
         even_waddr = HALF_AW'((wr.idx >> 1) + 1'b1);
         even_wdata = wr.hi;
         odd_wdata  = wr.lo;
         even_we    = wr.hi_en;
         odd_we     = wr.lo_en;
      end else begin
         even_waddr = HALF_AW'(wr.idx >> 1);
         even_wdata = wr.lo;
         odd_wdata  = wr.hi;
         even_we    = wr.lo_en;
         odd_we     = wr.hi_en;
      end
      even_raddr = HALF_AW'(({1'b0, rd.idx} + 1'b1) >> 1);
      odd_raddr  = HALF_AW'(rd.idx >> 1);
   end

   for (genvar b = 0; b < 2; b++) begin : g_bank
      pgs_ram #(.WIDTH(BYTE_BITS), .DEPTH(HALF_DEPTH)) u_even (
         .clock  (clock),
         .wr_en  (even_we && (wr.bank == 1'(b))),
         .wr_addr(even_waddr),
         .wr_data(even_wdata),
         .rd_addr(even_raddr),
         .rd_data(even_q[b])
      );
      pgs_ram #(.WIDTH(BYTE_BITS), .DEPTH(HALF_DEPTH)) u_odd (
         .clock  (clock),
         .wr_en  (odd_we && (wr.bank == 1'(b))),
         .wr_addr(odd_waddr),
         .wr_data(odd_wdata),
         .rd_addr(odd_raddr),
         .rd_data(odd_q[b])
      );
   end

   always_ff @(posedge clock) begin
      rd_bank_ff <= rd.bank;
      rd_odd_ff  <= rd.idx[0];
   end

   always_comb begin
      if (rd_odd_ff) begin
         rd_pair = {even_q[rd_bank_ff], odd_q[rd_bank_ff]};
      end else begin
         rd_pair = {odd_q[rd_bank_ff], even_q[rd_bank_ff]};
      end
   end

endmodule

// ===== sv/packed_3bit_grid_store.sv =====
// Top level of the packed 3-bit grid store: request decode, cell access and resize copy.
//
// A row-major grid of 3-bit cells lives densely packed in byte memory; a cell
// may straddle two bytes. Each request (start high while busy is low) is a
// read, a write or a resize. Every request gives exactly one response on
// rsp_cell_out / rsp_status, marked by rsp_valid for one cycle; the receiver
// cannot stall, so the response is simply taken in that cycle.
//
// Read and write: busy through an address state, then a data / write-back state
// of the byte-pair RMW, response in the cycle after; start may be accepted again
// in that response cycle. Resize: busy through a set-up state, a copy state per
// cell of the new layout, a drain state and a flush state, or set-up then flush
// when either count is zero. The copy streams one cell per cycle from the
// active bank into the other bank, packing bytes as they fill, then swaps banks.
// It is paced by the single read port of the active bank. A resize beyond the
// limits and the unused opcode answer straight from the set-up state.
// Out-of-range coordinates or limits: status 1, cell 0, nothing changes.
//
// Reset: active bank a, empty grid. No clearing pass: with an empty grid no
// byte is visible until a resize has rewritten every cell of the new layout.
module packed_3bit_grid_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_opcode,
   input  logic [pgs_pkg::ROW_W-1:0]     req_row,
   input  logic [pgs_pkg::COL_W-1:0]     req_column,
   input  logic [pgs_pkg::CELL_BITS-1:0] req_cell_in,
   input  logic [pgs_pkg::DIM_W-1:0]     req_new_rows,
   input  logic [pgs_pkg::DIM_W-1:0]     req_new_cols,
   output logic                          rsp_valid,
   output logic [pgs_pkg::CELL_BITS-1:0] rsp_cell_out,
   output logic                          rsp_status
);
   import pgs_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_DATA  = 6'b000100,
      ST_COPY  = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_FLUSH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // request holding registers
   opcode_type           op_ff, op_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [CELL_BITS-1:0] val_ff, val_in;
   logic [DIM_W-1:0]     nr_ff, nr_in;
   logic [DIM_W-1:0]     nc_ff, nc_in;

   // grid state
   logic                 bank_ff, bank_in;
   logic [DIM_W-1:0]     cur_rows_ff, cur_rows_in;
   logic [DIM_W-1:0]     cur_cols_ff, cur_cols_in;

   // cell access
   logic [OFF_W-1:0]     off_ff, off_in;
   logic                 err_ff, err_in;

   // resize walker
   logic [DIM_W-1:0]     i_ff, i_in;
   logic [DIM_W-1:0]     j_ff, j_in;
   logic [DIM_W-1:0]     rows_ov_ff, rows_ov_in;
   logic [DIM_W-1:0]     cols_ov_ff, cols_ov_in;
   logic [BIT_W-1:0]     stride_ff, stride_in;
   logic [BIT_W-1:0]     src_row_ff, src_row_in;
   logic [BIT_W-1:0]     src_bit_ff, src_bit_in;
   logic                 v1_ff, v1_in;
   logic                 ov1_ff, ov1_in;
   logic [OFF_W-1:0]     off1_ff, off1_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     wk_ff, wk_in;

   // response
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CELL_BITS-1:0] rsp_cell_ff, rsp_cell_in;
   logic                 rsp_status_ff, rsp_status_in;

   mem_rd_type           mem_rd;
   mem_wr_type           mem_wr;
   logic [2*BYTE_BITS-1:0] rd_pair;

   // combinational helpers
   logic [POS_W+1:0]       prod;
   logic [POS_W-1:0]       pos;
   logic [BIT_W-1:0]       cell_bit;
   logic [2*BYTE_BITS-1:0] pair_sh;
   logic [2*BYTE_BITS-1:0] pair_mask;
   logic [2*BYTE_BITS-1:0] pair_new;
   logic [CELL_BITS-1:0]   rd_cell;
   logic [CELL_BITS-1:0]   push_val;
   logic [BYTE_BITS+1:0]   combined;
   logic [CNT_W:0]         cnt_sum;
   logic                   accept;

   assign accept = start && (state_ff == ST_IDLE);

   pgs_banks u_banks (
      .clock  (clock),
      .rd     (mem_rd),
      .wr     (mem_wr),
      .rd_pair(rd_pair)
   );

   always_comb begin
      // defaults: hold everything
      state_in      = state_ff;
      op_in         = op_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      val_in        = val_ff;
      nr_in         = nr_ff;
      nc_in         = nc_ff;
      bank_in       = bank_ff;
      cur_rows_in   = cur_rows_ff;
      cur_cols_in   = cur_cols_ff;
      off_in        = off_ff;
      err_in        = err_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      rows_ov_in    = rows_ov_ff;
      cols_ov_in    = cols_ov_ff;
      stride_in     = stride_ff;
      src_row_in    = src_row_ff;
      src_bit_in    = src_bit_ff;
      v1_in         = 1'b0;
      ov1_in        = ov1_ff;
      off1_in       = off1_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      wk_in         = wk_ff;
      rsp_valid_in  = 1'b0;
      rsp_cell_in   = rsp_cell_ff;
      rsp_status_in = rsp_status_ff;

      // cell address of the held request: pos = row * cols + column, bit = 3 * pos
      prod     = (POS_W + 2)'(row_ff) * (POS_W + 2)'(cur_cols_ff) + (POS_W + 2)'(col_ff);
      pos      = prod[POS_W-1:0];
      cell_bit = (BIT_W'(pos) << 1) + BIT_W'(pos);

      mem_rd.bank = bank_ff;
      mem_rd.idx  = (state_ff == ST_COPY) ? src_bit_ff[BIT_W-1:3] : cell_bit[BIT_W-1:3];

      mem_wr = '0;
      mem_wr.bank = bank_ff;

      // cell RMW on the byte pair read back
      pair_sh   = rd_pair >> off_ff;
      rd_cell   = pair_sh[CELL_BITS-1:0];
      pair_mask = (2*BYTE_BITS)'(CELL_MASK) << off_ff;
      pair_new  = (rd_pair & ~pair_mask) | ((2*BYTE_BITS)'(val_ff) << off_ff);

      // resize packer: append the cell that came back from the source bank
      pair_sh  = rd_pair >> off1_ff;
      push_val = (v1_ff && ov1_ff) ? pair_sh[CELL_BITS-1:0] : '0;
      combined = (BYTE_BITS + 2)'(acc_ff) | ((BYTE_BITS + 2)'(push_val) << cnt_ff);
      cnt_sum  = (CNT_W + 1)'(cnt_ff) + (CNT_W + 1)'(CELL_BITS);

      if (v1_ff) begin
         if (cnt_sum >= (CNT_W + 1)'(BYTE_BITS)) begin
            mem_wr.bank  = ~bank_ff;
            mem_wr.idx   = wk_ff;
            mem_wr.lo_en = 1'b1;
            mem_wr.lo    = combined[BYTE_BITS-1:0];
            wk_in        = wk_ff + 1'b1;
            acc_in       = ACC_W'(combined >> BYTE_BITS);
            cnt_in       = CNT_W'(cnt_sum - (CNT_W + 1)'(BYTE_BITS));
         end else begin
            acc_in = combined[ACC_W-1:0];
            cnt_in = cnt_sum[CNT_W-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = opcode_type'(req_opcode);
               row_in   = req_row;
               col_in   = req_column;
               val_in   = req_cell_in;
               nr_in    = req_new_rows;
               nc_in    = req_new_cols;
               state_in = ST_READ;
            end
         end

         ST_READ: begin
            // read/write: the pair read is in flight; resize: check limits, set up walk; unused opcode: answer
            err_in = (DIM_W'(row_ff) >= cur_rows_ff) || (DIM_W'(col_ff) >= cur_cols_ff);
            off_in = cell_bit[OFF_W-1:0];
            unique case (op_ff) inside
               OP_READ, OP_WRITE: begin
                  state_in = ST_DATA;
               end
               OP_RESIZE: begin
                  if ((nr_ff > DIM_W'(MAX_ROWS)) || (nc_ff > DIM_W'(MAX_COLS))) begin
                     rsp_valid_in  = 1'b1;
                     rsp_cell_in   = '0;
                     rsp_status_in = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     rows_ov_in = (cur_rows_ff < nr_ff) ? cur_rows_ff : nr_ff;
                     cols_ov_in = (cur_cols_ff < nc_ff) ? cur_cols_ff : nc_ff;
                     stride_in  = (BIT_W'(cur_cols_ff) << 1) + BIT_W'(cur_cols_ff);
                     i_in       = '0;
                     j_in       = '0;
                     src_row_in = '0;
                     src_bit_in = '0;
                     acc_in     = '0;
                     cnt_in     = '0;
                     wk_in      = '0;
                     state_in   = ((nr_ff == '0) || (nc_ff == '0)) ? ST_FLUSH : ST_COPY;
                  end
               end
               default: begin
                  rsp_valid_in  = 1'b1;
                  rsp_cell_in   = '0;
                  rsp_status_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            endcase
         end

         ST_DATA: begin
            if ((op_ff == OP_WRITE) && !err_ff) begin
               mem_wr.bank  = bank_ff;
               mem_wr.idx   = cell_bit[BIT_W-1:3];
               mem_wr.lo_en = 1'b1;
               mem_wr.hi_en = (off_ff > OFF_W'(BYTE_BITS - CELL_BITS));
               mem_wr.lo    = pair_new[BYTE_BITS-1:0];
               mem_wr.hi    = pair_new[2*BYTE_BITS-1:BYTE_BITS];
            end
            rsp_valid_in  = 1'b1;
            rsp_cell_in   = ((op_ff == OP_READ) && !err_ff) ? rd_cell : '0;
            rsp_status_in = err_ff;
            state_in      = ST_IDLE;
         end

         ST_COPY: begin
            // issue one source cell per cycle, in new-layout order
            v1_in   = 1'b1;
            ov1_in  = (i_ff < rows_ov_ff) && (j_ff < cols_ov_ff);
            off1_in = src_bit_ff[OFF_W-1:0];
            if ((j_ff + 1'b1) == nc_ff) begin
               j_in       = '0;
               i_in       = i_ff + 1'b1;
               src_row_in = src_row_ff + stride_ff;
               src_bit_in = src_row_ff + stride_ff;
               if ((i_ff + 1'b1) == nr_ff) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               j_in       = j_ff + 1'b1;
               src_bit_in = src_bit_ff + BIT_W'(CELL_BITS);
            end
         end

         ST_DRAIN: begin
            state_in = ST_FLUSH;
         end

         ST_FLUSH: begin
            // write the partial last byte, then swap banks
            if (cnt_ff != '0) begin
               mem_wr.bank  = ~bank_ff;
               mem_wr.idx   = wk_ff;
               mem_wr.lo_en = 1'b1;
               mem_wr.lo    = BYTE_BITS'(acc_ff);
            end
            bank_in       = ~bank_ff;
            cur_rows_in   = nr_ff;
            cur_cols_in   = nc_ff;
            rsp_valid_in  = 1'b1;
            rsp_cell_in   = '0;
            rsp_status_in = 1'b0;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= 1'b0;
         cur_rows_ff  <= '0;
         cur_cols_ff  <= '0;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         cur_rows_ff  <= cur_rows_in;
         cur_cols_ff  <= cur_cols_in;
         v1_ff        <= v1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and walker registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      val_ff        <= val_in;
      nr_ff         <= nr_in;
      nc_ff         <= nc_in;
      off_ff        <= off_in;
      err_ff        <= err_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      rows_ov_ff    <= rows_ov_in;
      cols_ov_ff    <= cols_ov_in;
      stride_ff     <= stride_in;
      src_row_ff    <= src_row_in;
      src_bit_ff    <= src_bit_in;
      ov1_ff        <= ov1_in;
      off1_ff       <= off1_in;
      acc_ff        <= acc_in;
      cnt_ff        <= cnt_in;
      wk_ff         <= wk_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cell_out = rsp_cell_ff;
   assign rsp_status   = rsp_status_ff;

   // a response always lands in an idle cycle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // finishing a resize always answers in the next cycle
   a_flush_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |=> rsp_valid)
      else $error("resize finished without a response");

   // the resize copy never writes into the bank it is reading from
   a_copy_bank: assert property (@(posedge clock) disable iff (reset)
      (mem_wr.lo_en && (state_ff != ST_DATA)) |-> (mem_wr.bank != bank_ff))
      else $error("resize wrote the active bank");

   // cells come back from the source bank only while the walk runs
   a_walk_window: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> ((state_ff == ST_COPY) || (state_ff == ST_DRAIN)))
      else $error("resize data outside the copy walk");

endmodule

// ===== sim/grid_store_monitor.sv =====
// Request/response monitor with a cell-level predictor for the packed 3-bit grid store.
`timescale 1ns / 1ps
module grid_store_monitor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [1:0]                    req_opcode,
   input  logic [pgs_pkg::ROW_W-1:0]     req_row,
   input  logic [pgs_pkg::COL_W-1:0]     req_column,
   input  logic [pgs_pkg::CELL_BITS-1:0] req_cell_in,
   input  logic [pgs_pkg::DIM_W-1:0]     req_new_rows,
   input  logic [pgs_pkg::DIM_W-1:0]     req_new_cols,
   input  logic                          rsp_valid,
   input  logic [pgs_pkg::CELL_BITS-1:0] rsp_cell_out,
   input  logic                          rsp_status,
   output int                            fail_count,
   output int                            pending
);
   import pgs_pkg::*;

   localparam int GRID_CELLS = MAX_ROWS * MAX_COLS;

   typedef struct {
      logic [CELL_BITS-1:0] cell_value;
      logic                 status;
   } cell_reply_type;

   // cells kept by linear position, one entry per cell, not packed into bytes
   logic [CELL_BITS-1:0] grid_cells [GRID_CELLS];
   int unsigned          grid_rows;
   int unsigned          grid_cols;
   cell_reply_type       expected_replies [$];

   task automatic apply_request(input opcode_type op, input int unsigned row, col, nr, nc,
                                input logic [CELL_BITS-1:0] val,
                                output cell_reply_type reply);
      logic [CELL_BITS-1:0] fresh [GRID_CELLS];
      int unsigned          keep_rows;
      int unsigned          keep_cols;
      int unsigned          i;
      int unsigned          j;
      reply.cell_value = '0;
      reply.status     = 1'b0;
      case (op) inside
         OP_READ, OP_WRITE: begin
            if (row >= grid_rows || col >= grid_cols) begin
               reply.status = 1'b1;
            end else if (op == OP_READ) begin
               reply.cell_value = grid_cells[row * grid_cols + col];
            end else begin
               grid_cells[row * grid_cols + col] = val;
            end
         end
         OP_RESIZE: begin
            if (nr > MAX_ROWS || nc > MAX_COLS) begin
               reply.status = 1'b1;
            end else begin
               keep_rows = (grid_rows < nr) ? grid_rows : nr;
               keep_cols = (grid_cols < nc) ? grid_cols : nc;
               for (i = 0; i < GRID_CELLS; i++) fresh[i] = '0;
               for (i = 0; i < keep_rows; i++)
                  for (j = 0; j < keep_cols; j++)
                     fresh[i * nc + j] = grid_cells[i * grid_cols + j];
               for (i = 0; i < GRID_CELLS; i++) grid_cells[i] = fresh[i];
               grid_rows = nr;
               grid_cols = nc;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : track
      cell_reply_type want;
      int             k;
      if (reset) begin
         expected_replies.delete();
         for (k = 0; k < GRID_CELLS; k++) grid_cells[k] = '0;
         grid_rows  = 0;
         grid_cols  = 0;
         fail_count = 0;
      end else begin
         // compare first: a response never belongs to a request taken at the same edge
         if (rsp_valid) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: response with no request waiting, cell_out %0d status %0d",
                        $time, rsp_cell_out, rsp_status);
               fail_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_cell_out !== want.cell_value) begin
                  $display("%0t: cell_out mismatch, expected %0d, actual %0d",
                           $time, want.cell_value, rsp_cell_out);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            apply_request(opcode_type'(req_opcode), 32'(req_row), 32'(req_column),
                          32'(req_new_rows), 32'(req_new_cols), req_cell_in, want);
            expected_replies.push_back(want);
         end
      end
      pending <= expected_replies.size();
   end

endmodule

// ===== sim/tb.sv =====
// Stimulus, clock, reset, watchdog and verdict for the packed 3-bit grid store.
`timescale 1ns / 1ps
module tb;
   import pgs_pkg::*;

   localparam int RANDOM_REQUESTS = 1300;
   // the limit must outlast the busy time of a full 32x32 resize, the longest request
   localparam int STALL_LIMIT     = 5000;
   // linger after the last response to catch stray ones
   localparam int DRAIN_CYCLES    = 20;
   localparam int DIM_TOP         = (1 << DIM_W) - 1;
   localparam int ROW_TOP         = (1 << ROW_W) - 1;
   localparam int COL_TOP         = (1 << COL_W) - 1;
   localparam int CELL_TOP        = (1 << CELL_BITS) - 1;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [1:0]           req_opcode;
   logic [ROW_W-1:0]     req_row;
   logic [COL_W-1:0]     req_column;
   logic [CELL_BITS-1:0] req_cell_in;
   logic [DIM_W-1:0]     req_new_rows;
   logic [DIM_W-1:0]     req_new_cols;
   logic                 rsp_valid;
   logic [CELL_BITS-1:0] rsp_cell_out;
   logic                 rsp_status;

   int          fail_count;
   int          pending;
   int          idle_cycles = 0;
   // grid size as the stimulus sees it, used only to aim coordinates
   int unsigned shadow_rows;
   int unsigned shadow_cols;
   bit          gaps_on;

   packed_3bit_grid_store u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_row      (req_row),
      .req_column   (req_column),
      .req_cell_in  (req_cell_in),
      .req_new_rows (req_new_rows),
      .req_new_cols (req_new_cols),
      .rsp_valid    (rsp_valid),
      .rsp_cell_out (rsp_cell_out),
      .rsp_status   (rsp_status)
   );

   grid_store_monitor u_monitor (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_row      (req_row),
      .req_column   (req_column),
      .req_cell_in  (req_cell_in),
      .req_new_rows (req_new_rows),
      .req_new_cols (req_new_cols),
      .rsp_valid    (rsp_valid),
      .rsp_cell_out (rsp_cell_out),
      .rsp_status   (rsp_status),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // count cycles in which neither a request nor a response is taken
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Drive one request from a falling edge and hold it until taken. Insert random
   // gaps first; leave start high afterwards so back-to-back requests need no toggle.
   task automatic issue(input opcode_type op, input int unsigned row, col, val, nr, nc);
      while (gaps_on && $urandom_range(0, 99) < 22) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start        <= 1'b1;
      req_opcode   <= op;
      req_row      <= ROW_W'(row);
      req_column   <= COL_W'(col);
      req_cell_in  <= CELL_BITS'(val);
      req_new_rows <= DIM_W'(nr);
      req_new_cols <= DIM_W'(nc);
      if (op == OP_RESIZE && nr <= MAX_ROWS && nc <= MAX_COLS) begin
         shadow_rows = nr;
         shadow_cols = nc;
      end
      // busy is read before the edge's updates land, so a low value means taken
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Choose resize dimensions: mostly small grids, a few full ones, some empty
   // ones and some beyond the limits.
   task automatic pick_dims(output int unsigned nr, output int unsigned nc);
      int unsigned shape;
      int unsigned swap;
      shape = $urandom_range(0, 99);
      if (shape < 4) begin
         nr = MAX_ROWS;
         nc = MAX_COLS;
      end else if (shape < 14) begin
         nr = $urandom_range(0, DIM_TOP);
         nc = $urandom_range(MAX_COLS + 1, DIM_TOP);
      end else if (shape < 20) begin
         nr = $urandom_range(0, MAX_ROWS);
         nc = 0;
      end else if (shape < 40) begin
         nr = $urandom_range(1, MAX_ROWS);
         nc = $urandom_range(1, MAX_COLS);
      end else begin
         nr = $urandom_range(1, 8);
         nc = $urandom_range(1, 8);
      end
      // flip the shape so each limit and each empty side gets exercised
      if ($urandom_range(0, 1)) begin
         swap = nr;
         nr   = nc;
         nc   = swap;
      end
   endtask

   initial begin
      int unsigned n;
      int unsigned pick;
      bit          grid_empty;
      int unsigned nr;
      int unsigned nc;
      opcode_type  op;

      reset        = 1'b1;
      start        = 1'b0;
      req_opcode   = OP_READ;
      req_row      = '0;
      req_column   = '0;
      req_cell_in  = '0;
      req_new_rows = '0;
      req_new_cols = '0;
      shadow_rows  = 0;
      shadow_cols  = 0;
      gaps_on      = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty grid after reset: every access is flagged, the unused opcode is quiet
      issue(OP_READ, 0, 0, 0, 0, 0);
      issue(OP_WRITE, ROW_TOP, COL_TOP, CELL_TOP, DIM_TOP, DIM_TOP);
      issue(OP_NOP, ROW_TOP, COL_TOP, CELL_TOP, DIM_TOP, DIM_TOP);
      // resize beyond the row limit, the column limit and both
      issue(OP_RESIZE, 0, 0, 0, MAX_ROWS + 1, 1);
      issue(OP_RESIZE, 0, 0, 0, 1, MAX_COLS + 1);
      issue(OP_RESIZE, 0, 0, 0, DIM_TOP, DIM_TOP);
      // empty resize, then a write that must still be flagged
      issue(OP_RESIZE, 0, 0, 0, 0, 5);
      issue(OP_WRITE, 0, 0, 5, 0, 0);
      // full-size grid; hit cells that straddle byte boundaries and the last cell
      issue(OP_RESIZE, 0, 0, 0, MAX_ROWS, MAX_COLS);
      issue(OP_WRITE, 0, 0, CELL_TOP, 0, 0);
      issue(OP_WRITE, 0, 2, CELL_TOP, 0, 0);
      issue(OP_WRITE, 0, 5, 3, 0, 0);
      issue(OP_WRITE, ROW_TOP, COL_TOP, 5, 0, 0);
      issue(OP_READ, 0, 2, 0, 0, 0);
      issue(OP_READ, 0, 5, 0, 0, 0);
      issue(OP_READ, ROW_TOP, COL_TOP, 0, 0, 0);
      // shrink keeps the overlap, then probe just past each edge
      issue(OP_RESIZE, 0, 0, 0, 3, 5);
      issue(OP_READ, 0, 2, 0, 0, 0);
      issue(OP_READ, 3, 0, 0, 0, 0);
      issue(OP_READ, 0, 5, 0, 0, 0);
      // grow: old cells move to new positions, new cells read zero
      issue(OP_RESIZE, 0, 0, 0, 6, 7);
      issue(OP_READ, 0, 2, 0, 0, 0);
      issue(OP_READ, 5, 6, 0, 0, 0);
      issue(OP_RESIZE, 0, 0, 0, MAX_ROWS, 0);
      issue(OP_READ, 0, 0, 0, 0, 0);

      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         // hold the request side busy without gaps through a long middle stretch
         gaps_on    = !(n >= 500 && n < 800);
         pick       = $urandom_range(0, 99);
         grid_empty = (shadow_rows == 0 || shadow_cols == 0);
         if (pick < 5 || (grid_empty && pick >= 16)) begin
            pick_dims(nr, nc);
            issue(OP_RESIZE, $urandom_range(0, ROW_TOP), $urandom_range(0, COL_TOP),
                  $urandom_range(0, CELL_TOP), nr, nc);
         end else if (pick < 9) begin
            issue(OP_NOP, $urandom_range(0, ROW_TOP), $urandom_range(0, COL_TOP),
                  $urandom_range(0, CELL_TOP), $urandom_range(0, DIM_TOP),
                  $urandom_range(0, DIM_TOP));
         end else begin
            op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
            if (pick < 16) begin
               // noise: coordinates anywhere, often outside the grid
               issue(op, $urandom_range(0, ROW_TOP), $urandom_range(0, COL_TOP),
                     $urandom_range(0, CELL_TOP), $urandom_range(0, DIM_TOP),
                     $urandom_range(0, DIM_TOP));
            end else begin
               issue(op, $urandom_range(0, shadow_rows - 1), $urandom_range(0, shadow_cols - 1),
                     $urandom_range(0, CELL_TOP), $urandom_range(0, DIM_TOP),
                     $urandom_range(0, DIM_TOP));
            end
         end
      end
      start <= 1'b0;

      // drain the outstanding responses, then linger for stray ones
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
